// File: hw/rtl/mmh_pkg.sv
// mmh_pkg: shared types, constants and state encoding for the min-max heap engine
// no dependencies
`timescale 1ns / 1ps
package mmh_pkg;

  localparam int unsigned CAPACITY_DEF = 1023;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_RMIN   = 2'd1,
    ACT_RMAX   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [9:0]         count;
  } out_res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RDP,    // read parent
    S_INS_WTP,
    S_INS_CMPP,
    S_UP_RD,      // read grandparent
    S_UP_WT,
    S_UP_CMP,
    S_UP_FIN,
    S_RM_RD2,
    S_RM_RD3,
    S_RM_WT,
    S_RM_SEL,
    S_RM_RDL,     // read target and last
    S_RM_WTL,
    S_RM_TAKE,
    S_TD_INIT,
    S_TD_RD,      // scan candidates
    S_TD_WT,
    S_TD_ACC,
    S_TD_DEC,
    S_TD_RDP,
    S_TD_WTP,
    S_TD_CMPP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_issue;
    logic rd_capture;
    logic ins_start;
    logic ins_cmp_parent;
    logic up_cmp;
    logic up_fin;
    logic rm_rd2;
    logic rm_cap2;
    logic rm_cap3;
    logic rm_select;
    logic rm_rd_last;
    logic rm_cap_last;
    logic rm_take;
    logic td_init;
    logic td_acc;
    logic td_decide;
    logic td_cmp_parent;
    logic finish;
  } mmh_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic is_insert;
    logic is_remove;
    logic ins_first;
    logic up_more;
    logic rm_need_sel;
    logic rm_no_td;
    logic td_more;
    logic td_cand_left;
    logic td_descend;
    logic td_swap;
  } mmh_sts_t;

endpackage

// File: hw/rtl/mmh_ctrl.sv
// mmh_ctrl: controller state machine sequencing insert, removal and trickle-down
// depends on mmh_pkg
`timescale 1ns / 1ps
module mmh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mmh_pkg::mmh_sts_t sts,
  output mmh_pkg::mmh_cmd_t cmd
);
  import mmh_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.is_insert && !sts.full) begin
            state_nxt = sts.ins_first ? S_UP_FIN : S_INS_RDP;
          end else if (sts.is_remove && !sts.empty) begin
            state_nxt = sts.rm_need_sel ? S_RM_RD2 : S_RM_RDL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INS_RDP:  state_nxt = S_INS_WTP;
      S_INS_WTP:  state_nxt = S_INS_CMPP;
      S_INS_CMPP: state_nxt = S_UP_RD;
      S_UP_CMP:   state_nxt = sts.up_more ? S_UP_RD : S_UP_FIN;
      S_UP_RD:    state_nxt = S_UP_WT;
      S_UP_WT:    state_nxt = S_UP_CMP;
      S_UP_FIN:   state_nxt = S_DONE;
      S_RM_RD2:   state_nxt = S_RM_RD3;
      S_RM_RD3:   state_nxt = S_RM_WT;
      S_RM_WT:    state_nxt = S_RM_SEL;
      S_RM_SEL:   state_nxt = S_RM_RDL;
      S_RM_RDL:   state_nxt = S_RM_WTL;
      S_RM_WTL:   state_nxt = S_RM_TAKE;
      S_RM_TAKE:  state_nxt = sts.rm_no_td ? S_DONE : S_TD_INIT;
      S_TD_INIT:  state_nxt = sts.td_more ? S_TD_RD : S_DONE;
      S_TD_RD:    state_nxt = S_TD_WT;
      S_TD_WT:    state_nxt = S_TD_ACC;
      S_TD_ACC:   state_nxt = sts.td_cand_left ? S_TD_RD : S_TD_DEC;
      S_TD_DEC: begin
        if (sts.td_descend) begin
          state_nxt = S_TD_RDP;
        end else if (sts.td_swap) begin
          state_nxt = S_UP_FIN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TD_RDP:   state_nxt = S_TD_WTP;
      S_TD_WTP:   state_nxt = S_TD_CMPP;
      S_TD_CMPP:  state_nxt = S_TD_INIT;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:     cmd.ins_start = start;
      S_INS_RDP:  cmd.rd_issue = 1'b1;
      S_INS_CMPP: cmd.ins_cmp_parent = 1'b1;
      S_UP_CMP:   cmd.up_cmp = 1'b1;
      S_UP_RD:    cmd.rd_issue = 1'b1;
      S_UP_FIN:   cmd.up_fin = 1'b1;
      S_RM_RD2: begin
        cmd.rd_issue = 1'b1;
        cmd.rm_rd2 = 1'b1;
      end
      S_RM_RD3: begin
        cmd.rd_issue = 1'b1;
        cmd.rm_cap2 = 1'b1;
      end
      S_RM_WT:    cmd.rm_cap3 = 1'b1;
      S_RM_SEL:   cmd.rm_select = 1'b1;
      S_RM_RDL: begin
        cmd.rd_issue = 1'b1;
        cmd.rm_rd_last = 1'b1;
      end
      S_RM_WTL: begin
        cmd.rd_issue = 1'b1;
        cmd.rm_cap_last = 1'b1;
      end
      S_RM_TAKE:  cmd.rm_take = 1'b1;
      S_TD_INIT:  cmd.td_init = 1'b1;
      S_TD_RD:    cmd.rd_issue = 1'b1;
      S_TD_ACC:   cmd.td_acc = 1'b1;
      S_TD_DEC:   cmd.td_decide = 1'b1;
      S_TD_RDP:   cmd.rd_issue = 1'b1;
      S_TD_CMPP:  cmd.td_cmp_parent = 1'b1;
      S_DONE:     cmd.finish = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/mmh_dp.sv
// mmh_dp: heap memory, index and key registers, comparators of the heap engine
// depends on mmh_pkg
`timescale 1ns / 1ps
module mmh_dp #(
  parameter int unsigned CAPACITY = mmh_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mmh_pkg::in_req_t  in_req,
  input  mmh_pkg::mmh_cmd_t cmd,
  output mmh_pkg::mmh_sts_t sts,
  output logic              out_valid,
  output mmh_pkg::out_res_t out_res
);
  import mmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 3;

  logic [31:0] mem [0:CAPACITY];
  logic [AW-1:0] raddr;
  logic [31:0] rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [AW-1:0] cnt_r;
  logic [1:0]    act_r;
  logic [31:0]   key_r;
  logic [IW-1:0] pos_r;
  logic          mode_min_r;
  logic [31:0]   k2_r, k3_r;
  logic [AW-1:0] tgt_r;
  logic [31:0]   res_r;
  logic [1:0]    stat_r;
  logic [IW-1:0] base_r;
  logic [2:0]    ci_r;
  logic [IW-1:0] best_r;
  logic [31:0]   bestk_r;
  logic [IW-1:0] rd_idx_r;
  logic          out_valid_r;
  logic [IW-1:0] cand;
  logic [IW-1:0] n_ext;
  logic          min_lvl;
  logic          bet;
  logic          ins_swap, up_move, td_write, par_swap, td_stop;
  logic [IW-1:0] gp;
  logic          nxt_cand_ok;
  logic [IW-1:0] cand_n;

  assign n_ext = IW'(cnt_r);
  assign raddr = rd_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_issue) rdata_r <= mem[raddr];
  end

  function automatic logic better(input logic [31:0] a, input logic [31:0] b,
                                  input logic is_min);
    better = is_min ? (a < b) : (a > b);
  endfunction

  always_comb begin
    min_lvl = 1'b1;
    for (int b = 1; b < AW; b++) begin
      if (cnt_r[b]) min_lvl = ~b[0];
    end
  end

  always_comb begin
    case (ci_r)
      3'd0: cand = {base_r[IW-2:0], 1'b0};
      3'd1: cand = {base_r[IW-2:0], 1'b1};
      3'd2: cand = {base_r[IW-3:0], 2'b00};
      3'd3: cand = {base_r[IW-3:0], 2'b01};
      3'd4: cand = {base_r[IW-3:0], 2'b10};
      default: cand = {base_r[IW-3:0], 2'b11};
    endcase
  end

  assign bet = better(bestk_r, key_r, mode_min_r);

  assign gp = {2'b00, pos_r[IW-1:2]};
  assign ins_swap = min_lvl ? (key_r > rdata_r) : (key_r < rdata_r);
  assign up_move = (pos_r >= IW'(4)) && better(key_r, rdata_r, mode_min_r);
  assign td_write = (best_r != '0) && bet;
  assign par_swap = better(rdata_r, key_r, mode_min_r);
  assign td_stop = cmd.td_decide && !td_write;

  always_comb begin
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = key_r;
    // memory writes
    if (cmd.ins_cmp_parent && ins_swap) begin
      we = 1'b1;
      waddr = cnt_r;
      wdata = rdata_r;
    end else if (cmd.up_cmp && up_move) begin
      we = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = rdata_r;
    end else if (cmd.up_fin) begin
      we = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = key_r;
    end else if (cmd.td_decide && td_write) begin
      we = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = bestk_r;
    end else if (cmd.td_cmp_parent && par_swap) begin
      we = 1'b1;
      waddr = pos_r[AW:1];
      wdata = key_r;
    end else if ((cmd.td_init && !sts.td_more) || td_stop) begin
      we = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = key_r;
    end
  end

  always_comb begin
    case (ci_r)
      3'd0: cand_n = {base_r[IW-2:0], 1'b1};
      3'd1: cand_n = {base_r[IW-3:0], 2'b00};
      3'd2: cand_n = {base_r[IW-3:0], 2'b01};
      3'd3: cand_n = {base_r[IW-3:0], 2'b10};
      default: cand_n = {base_r[IW-3:0], 2'b11};
    endcase
  end
  assign nxt_cand_ok = (cand_n <= n_ext);

  always_comb begin
    sts.full = (cnt_r >= AW'(CAPACITY));
    sts.empty = (cnt_r == '0);
    sts.is_insert = (in_req.action == ACT_INSERT);
    sts.is_remove = (in_req.action == ACT_RMIN) || (in_req.action == ACT_RMAX);
    sts.ins_first = (cnt_r == '0);
    sts.up_more = up_move && (gp >= IW'(4));
    sts.rm_need_sel = (in_req.action == ACT_RMAX) && (cnt_r > AW'(2));
    sts.rm_no_td = (IW'(tgt_r) >= n_ext);
    sts.td_more = ({pos_r[IW-2:0], 1'b0} <= n_ext);
    sts.td_cand_left = (ci_r != 3'd5) && (nxt_cand_ok);
    sts.td_descend = td_write && (best_r >= {base_r[IW-3:0], 2'b00});
    sts.td_swap = td_write;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.ins_start) begin
        act_r <= in_req.action;
        key_r <= in_req.value ^ 32'h8000_0000;
        res_r <= '0;
        stat_r <= ST_OK;
        if (in_req.action == ACT_INSERT) begin
          if (cnt_r >= AW'(CAPACITY)) begin
            stat_r <= ST_FULL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            pos_r <= IW'(cnt_r) + 1'b1;
            rd_idx_r <= (IW'(cnt_r) + 1'b1) >> 1;
            mode_min_r <= 1'b1;
          end
        end else if (in_req.action == ACT_RMIN || in_req.action == ACT_RMAX) begin
          if (cnt_r == '0) begin
            stat_r <= ST_EMPTY;
          end else begin
            mode_min_r <= (in_req.action == ACT_RMIN) || (cnt_r == AW'(1));
            if (in_req.action == ACT_RMIN || cnt_r == AW'(1)) begin
              tgt_r <= AW'(1);
              rd_idx_r <= IW'(1);
            end else begin
              tgt_r <= AW'(2);
              rd_idx_r <= IW'(2);
            end
          end
        end
      end
      if (cmd.rm_rd2) rd_idx_r <= IW'(3);
      if (cmd.rm_cap2) k2_r <= rdata_r;
      if (cmd.rm_cap3) k3_r <= rdata_r;
      if (cmd.rm_select) begin
        tgt_r <= (k2_r > k3_r) ? AW'(2) : AW'(3);
        rd_idx_r <= IW'((k2_r > k3_r) ? 2 : 3);
      end
      if (cmd.ins_cmp_parent) begin
        // min level of new slot decides direction
        if (ins_swap) begin
          pos_r <= pos_r >> 1;
          mode_min_r <= !min_lvl;
        end else begin
          mode_min_r <= min_lvl;
        end
        rd_idx_r <= (ins_swap ? (pos_r >> 1) : pos_r) >> 2;
      end
      if (cmd.up_cmp && up_move) begin
        pos_r <= gp;
        rd_idx_r <= gp >> 2;
      end
      if (cmd.rm_rd_last) rd_idx_r <= n_ext;
      if (cmd.rm_cap_last) res_r <= rdata_r ^ 32'h8000_0000;
      if (cmd.rm_take) begin
        key_r <= rdata_r;
        cnt_r <= cnt_r - 1'b1;
        pos_r <= IW'(tgt_r);
        base_r <= IW'(tgt_r);
      end
      if (cmd.td_init) begin
        base_r <= pos_r;
        ci_r <= 3'd0;
        best_r <= '0;
        rd_idx_r <= {pos_r[IW-2:0], 1'b0};
      end
      if (cmd.td_acc) begin
        if (best_r == '0 || better(rdata_r, bestk_r, mode_min_r)) begin
          best_r <= cand;
          bestk_r <= rdata_r;
        end
        ci_r <= ci_r + 1'b1;
        rd_idx_r <= cand_n;
      end
      if (cmd.td_decide && td_write) begin
        pos_r <= best_r;
        rd_idx_r <= best_r >> 1;
      end
      if (cmd.td_cmp_parent && par_swap) begin
        key_r <= rdata_r;
      end
      if (cmd.finish) begin
        out_res.result_value <= (act_r == ACT_RMIN || act_r == ACT_RMAX) && stat_r == ST_OK
                                ? res_r : '0;
        out_res.status <= stat_r;
        out_res.count <= 10'(cnt_r);
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/min_max_heap_engine.sv
// min_max_heap_engine: top level joining the heap controller and datapath
// depends on mmh_pkg, mmh_ctrl, mmh_dp
`timescale 1ns / 1ps
// A request is taken when start is high and busy low; one request runs at a time and its
// result appears for one cycle with out_valid, in the cycle in which busy falls, and cannot
// be held off. The single memory read port sets the time: an insert climbs grandparent by
// grandparent (the first key is written directly), and a removal descends two levels per
// step, since the six children and grandchildren are read one at a time.
module min_max_heap_engine #(
  parameter int unsigned CAPACITY = mmh_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mmh_pkg::in_req_t in_req,
  output logic             out_valid,
  output mmh_pkg::out_res_t out_res
);
  import mmh_pkg::*;

  mmh_cmd_t cmd;
  mmh_sts_t sts;

  mmh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  mmh_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_res(out_res)
  );

endmodule
